>>> src/assert_macros.svh
// Assertion macros shared by the level meter ballistics RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define LMB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked at the same edge
`define LMB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Implication checked at the next edge
`define LMB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/lmb_pkg.sv
// Package for the level meter ballistics unit: types, codes and constants
`timescale 1ns / 1ps

package lmb_pkg;

  localparam int unsigned LevelW  = 16;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned RateW   = 12;
  localparam int unsigned HeightW = 10;
  localparam int unsigned FracW   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned FallW   = RateW + TimeW;

  localparam logic [LevelW-1:0]  FullScale = 16'h8000;
  localparam logic [TimeW-1:0]   AgeMax    = 16'hFFFF;

  localparam logic [RateW-1:0]   DecayRateRst  = 12'd16;
  localparam logic [TimeW-1:0]   ClipHoldRst   = 16'd1000;
  localparam logic [TimeW-1:0]   TickHoldRst   = 16'd1500;
  localparam logic [HeightW-1:0] MeterHeightRst = 10'd200;
  localparam logic [FracW-1:0]   RedFracRst    = 8'd26;
  localparam logic [FracW-1:0]   YellowFracRst = 8'd51;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_DECAY_RATE   = 3'd0,
    REG_CLIP_HOLD    = 3'd1,
    REG_TICK_HOLD    = 3'd2,
    REG_METER_HEIGHT = 3'd3,
    REG_RED_FRAC     = 3'd4,
    REG_YELLOW_FRAC  = 3'd5
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DECAY,
    ST_BAR,
    ST_FINISH
  } lmb_state_e;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [TimeW-1:0]  elapsed_ms;
  } in_req_t;

  typedef struct packed {
    logic [LevelW-1:0]  shown_level;
    logic [HeightW-1:0] bar_height;
    logic [HeightW-1:0] green_len;
    logic [HeightW-1:0] yellow_len;
    logic [HeightW-1:0] red_len;
    logic [HeightW-1:0] tick_pos;
    logic               clip_lit;
  } out_res_t;

  typedef struct packed {
    logic [RateW-1:0]   decay_rate;
    logic [TimeW-1:0]   clip_hold_ms;
    logic [TimeW-1:0]   tick_hold_ms;
    logic [HeightW-1:0] meter_height;
    logic [FracW-1:0]   red_fraction;
    logic [FracW-1:0]   yellow_fraction;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic step_mul;
    logic step_decay;
    logic step_bar;
    logic finish;
  } lmb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } lmb_status_t;

endpackage

>>> src/lmb_cfg_regs.sv
// Configuration register bank of the level meter ballistics unit
`timescale 1ns / 1ps

module lmb_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lmb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lmb_pkg::CfgDataW-1:0]  cfg_data_i,
  output lmb_pkg::cfg_t                 cfg_o
);
  import lmb_pkg::*;

  cfg_t cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decay_rate      <= DecayRateRst;
      cfg_q.clip_hold_ms    <= ClipHoldRst;
      cfg_q.tick_hold_ms    <= TickHoldRst;
      cfg_q.meter_height    <= MeterHeightRst;
      cfg_q.red_fraction    <= RedFracRst;
      cfg_q.yellow_fraction <= YellowFracRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_DECAY_RATE:   cfg_q.decay_rate      <= cfg_data_i[RateW-1:0];
        REG_CLIP_HOLD:    cfg_q.clip_hold_ms    <= cfg_data_i[TimeW-1:0];
        REG_TICK_HOLD:    cfg_q.tick_hold_ms    <= cfg_data_i[TimeW-1:0];
        REG_METER_HEIGHT: cfg_q.meter_height    <= cfg_data_i[HeightW-1:0];
        REG_RED_FRAC:     cfg_q.red_fraction    <= cfg_data_i[FracW-1:0];
        REG_YELLOW_FRAC:  cfg_q.yellow_fraction <= cfg_data_i[FracW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/lmb_ctrl.sv
// Sequencer that steps one meter update through the datapath
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lmb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lmb_pkg::lmb_status_t status_i,
  output lmb_pkg::lmb_cmd_t    cmd_o
);
  import lmb_pkg::*;

  lmb_state_e state_q, state_d;
  logic       in_take;

  // A request is taken when idle, or as the previous result leaves the final step
  assign in_stall_o = !((state_q == ST_IDLE) ||
                        ((state_q == ST_FINISH) && status_i.out_free));
  assign in_take    = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_take) state_d = ST_MUL;
      ST_MUL:    state_d = ST_DECAY;
      ST_DECAY:  state_d = ST_BAR;
      ST_BAR:    state_d = ST_FINISH;
      ST_FINISH: begin
        if (status_i.out_free) state_d = in_take ? ST_MUL : ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.load_in    = in_take;
    cmd_o.step_mul   = (state_q == ST_MUL);
    cmd_o.step_decay = (state_q == ST_DECAY);
    cmd_o.step_bar   = (state_q == ST_BAR);
    cmd_o.finish     = (state_q == ST_FINISH) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `LMB_ASSERT_NXT(a_take_starts_mul, in_take, state_q == ST_MUL, "accepted request did not start")
  `LMB_ASSERT_NXT(a_finish_waits, (state_q == ST_FINISH) && !status_i.out_free,
                  state_q == ST_FINISH, "finish step left while output was full")

endmodule

>>> src/lmb_datapath.sv
// Datapath: decay, clip lamp, bar scaling, zone split, peak tick and output register
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lmb_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lmb_pkg::cfg_t        cfg_i,
  input  lmb_pkg::in_req_t     in_req_i,
  input  lmb_pkg::lmb_cmd_t    cmd_i,
  output lmb_pkg::lmb_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lmb_pkg::out_res_t    out_res_o
);
  import lmb_pkg::*;

  // Request registers
  logic [LevelW-1:0] level_q;
  logic [TimeW-1:0]  dt_q;
  logic              full_q;

  // Intermediate registers
  logic [FallW-1:0]   fall_q;
  logic [HeightW-1:0] red_q, yellow_q;
  logic [HeightW-1:0] green_zone_q, yellow_zone_q;
  logic [HeightW-1:0] bar_q;
  logic               lit_q;

  // Meter state
  logic [LevelW-1:0]  disp_q, disp_d;
  logic [HeightW-1:0] tick_h_q, tick_h_d;
  logic [TimeW-1:0]   tick_age_q, tick_age_d;
  logic [TimeW-1:0]   clip_age_q, clip_age_d;

  // Output register
  logic     out_valid_q;
  out_res_t out_res_q, out_res_d;

  logic [LevelW-1:0]          level_sat;
  logic [HeightW+FracW-1:0]   red_prod, yellow_prod;
  logic [TimeW:0]             clip_sum, tick_sum;
  logic [TimeW-1:0]           tick_age_sat;
  logic [LevelW-1:0]          diff;
  logic                       snap;
  logic [HeightW-1:0]         room, yellow_cut;
  logic [HeightW+LevelW-1:0]  bar_prod;
  logic [HeightW-1:0]         glen, rem, ylen;
  logic                       tick_move;

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // Input saturation to full scale
  assign level_sat = (in_req_i.level > FullScale) ? FullScale : in_req_i.level;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      level_q <= level_sat;
      dt_q    <= in_req_i.elapsed_ms;
      full_q  <= (level_sat == FullScale);
    end
  end

  // Step 1: decay fall, zone sizes, clip lamp
  assign red_prod    = cfg_i.meter_height * cfg_i.red_fraction;
  assign yellow_prod = cfg_i.meter_height * cfg_i.yellow_fraction;
  assign clip_sum    = {1'b0, clip_age_q} + {1'b0, dt_q};
  assign clip_age_d  = full_q ? '0 : (clip_sum[TimeW] ? AgeMax : clip_sum[TimeW-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_mul) begin
      fall_q   <= cfg_i.decay_rate * dt_q;
      red_q    <= red_prod[HeightW+FracW-1:FracW];
      yellow_q <= yellow_prod[HeightW+FracW-1:FracW];
      lit_q    <= full_q || (clip_age_d < cfg_i.clip_hold_ms);
    end
  end

  // Step 2: new displayed level, clipped zones
  assign diff   = disp_q - level_q;
  assign snap   = (level_q >= disp_q) || (disp_q == '0) ||
                  (fall_q >= {{(FallW-LevelW){1'b0}}, diff});
  assign disp_d = snap ? level_q : (disp_q - fall_q[LevelW-1:0]);
  assign room       = cfg_i.meter_height - red_q;
  assign yellow_cut = (yellow_q > room) ? room : yellow_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_decay) begin
      green_zone_q  <= room - yellow_cut;
      yellow_zone_q <= yellow_cut;
    end
  end

  // Step 3: bar height; product stays below 2^25 so bits 24:15 hold it
  assign bar_prod = cfg_i.meter_height * disp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_bar) begin
      bar_q <= bar_prod[HeightW+LevelW-2:LevelW-1];
    end
  end

  // Step 4: zone lengths and peak tick
  assign glen = (bar_q < green_zone_q) ? bar_q : green_zone_q;
  assign rem  = bar_q - glen;
  assign ylen = (rem < yellow_zone_q) ? rem : yellow_zone_q;
  assign tick_sum     = {1'b0, tick_age_q} + {1'b0, dt_q};
  assign tick_age_sat = tick_sum[TimeW] ? AgeMax : tick_sum[TimeW-1:0];
  assign tick_move    = (bar_q > tick_h_q) || (tick_age_sat > cfg_i.tick_hold_ms);
  assign tick_h_d     = tick_move ? bar_q : tick_h_q;
  assign tick_age_d   = tick_move ? '0 : tick_age_sat;

  always_comb begin
    out_res_d.shown_level = disp_q;
    out_res_d.bar_height  = bar_q;
    out_res_d.green_len   = glen;
    out_res_d.yellow_len  = ylen;
    out_res_d.red_len     = rem - ylen;
    out_res_d.tick_pos    = tick_h_d;
    out_res_d.clip_lit    = lit_q;
  end

  // Meter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_q     <= '0;
      tick_h_q   <= '0;
      tick_age_q <= '0;
      clip_age_q <= AgeMax;
    end else begin
      if (cmd_i.step_mul)   clip_age_q <= clip_age_d;
      if (cmd_i.step_decay) disp_q     <= disp_d;
      if (cmd_i.finish) begin
        tick_h_q   <= tick_h_d;
        tick_age_q <= tick_age_d;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) out_res_q <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  `LMB_ASSERT_IMP(a_len_sum, out_valid_q,
                  out_res_q.green_len + out_res_q.yellow_len + out_res_q.red_len ==
                  out_res_q.bar_height, "zone lengths do not add up to the bar")
  `LMB_ASSERT_NXT(a_out_hold, out_valid_q && out_stall_i,
                  out_valid_q && $stable(out_res_q), "stalled result changed")
  `LMB_ASSERT_NXT(a_finish_valid, cmd_i.finish, out_valid_q, "finished result not presented")

endmodule

>>> src/level_meter_ballistics_unit.sv
// Top level of the level meter ballistics unit
`timescale 1ns / 1ps

// Peak meter with decay, peak-hold tick and clip lamp. Each request carries a
// Q1.15 level and the milliseconds since the previous request and yields one
// result. A request runs through a four-step sequencer (multiply, decay, bar
// scale, finish) over a shared datapath, so a request is not taken until the
// previous one has finished: the next request is accepted on the edge that
// the previous result leaves the finish step and enters the output register. A
// full output register that is stalled holds the sequencer in its finish step.
// Configuration writes go straight to the register bank and must happen only
// while the unit is idle.
module level_meter_ballistics_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lmb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lmb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  lmb_pkg::in_req_t             in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output lmb_pkg::out_res_t            out_res_o
);
  import lmb_pkg::*;

  cfg_t        cfg;
  lmb_cmd_t    cmd;
  lmb_status_t status;

  lmb_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lmb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lmb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule
